### rtl/rgbled_pkg.sv
`default_nettype none

package rgbled_pkg;

  localparam int TABLE_BYTES_DEF = 30;
  localparam int OFFSET_STEP_DEF = 3;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_START = 2'd1,
    KIND_TICK  = 2'd2
  } kind_t;

  localparam logic [1:0] CFG_ONE_HIGH  = 2'd0;
  localparam logic [1:0] CFG_ZERO_HIGH = 2'd1;
  localparam logic [1:0] CFG_BIT_SLOTS = 2'd2;

  localparam logic [3:0] ONE_HIGH_RST  = 4'd6;
  localparam logic [3:0] ZERO_HIGH_RST = 4'd4;
  localparam logic [4:0] BIT_SLOTS_RST = 5'd10;

  localparam logic [4:0] BIT_SLOTS_MIN = 5'd2;
  localparam logic [4:0] BIT_SLOTS_MAX = 5'd16;

endpackage

`default_nettype wire

### rtl/rgb_led_serial_frame_sender.sv
`default_nettype none

// LED strip frame sender. Write requests load a table of TABLE_BYTES colour bytes
// (green, red, blue per LED), a start request begins a frame and every tick request is
// one slot of the serial line. A new request is taken every cycle unless the output
// register holds a result not yet taken by out_ready: the result goes into that register,
// and the table byte for the next slot is read from the table memory, with a write to
// that same entry forwarded, into a read register in the same cycle. A frame walks the
// whole table from the start offset, which moves on by OFFSET_STEP after each frame,
// or back to zero past the end. Table entries must be written before a frame reads them.
module rgb_led_serial_frame_sender #(
  parameter int TABLE_BYTES = rgbled_pkg::TABLE_BYTES_DEF,
  parameter int OFFSET_STEP = rgbled_pkg::OFFSET_STEP_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [4:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] kind,
  input  wire logic [4:0] entry_index,
  input  wire logic [7:0] entry_value,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            line_level,
  output logic            sending,
  output logic            frame_done
);

  localparam int AW = $clog2(TABLE_BYTES);
  localparam int SW = $clog2(TABLE_BYTES + OFFSET_STEP + 1);
  localparam logic [AW-1:0] LAST = AW'(TABLE_BYTES - 1);

  logic [7:0] colour_table [TABLE_BYTES];

  logic [3:0] one_high;
  logic [3:0] zero_high;
  logic [4:0] bit_slots;

  logic [AW-1:0] start_offset, start_offset_next;
  logic [AW-1:0] byte_count, byte_count_next;
  logic [AW-1:0] pos, pos_next;
  logic [2:0]    bit_position, bit_position_next;
  logic [3:0]    slot_count, slot_count_next;
  logic          busy, busy_next;
  logic [7:0]    rd_data;

  logic          accept;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic          line_next, sending_next, done_next;
  logic [4:0]    bit_len;
  logic [4:0]    slot_inc;
  logic [3:0]    high;
  logic          cur_bit;
  logic [SW-1:0] offset_sum;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign mem_addr = AW'(entry_index);

  always_comb begin
    if (bit_slots < rgbled_pkg::BIT_SLOTS_MIN) begin
      bit_len = rgbled_pkg::BIT_SLOTS_MIN;
    end else if (bit_slots > rgbled_pkg::BIT_SLOTS_MAX) begin
      bit_len = rgbled_pkg::BIT_SLOTS_MAX;
    end else begin
      bit_len = bit_slots;
    end
  end

  always_comb begin
    start_offset_next = start_offset;
    byte_count_next   = byte_count;
    pos_next          = pos;
    bit_position_next = bit_position;
    slot_count_next   = slot_count;
    busy_next         = busy;
    mem_we            = 1'b0;
    line_next         = 1'b0;
    done_next         = 1'b0;
    sending_next      = busy;
    cur_bit           = rd_data[3'd7 - bit_position];
    high              = cur_bit ? one_high : zero_high;
    slot_inc          = {1'b0, slot_count} + 5'd1;
    offset_sum        = SW'(start_offset) + SW'(OFFSET_STEP);
    if (accept) begin
      case (rgbled_pkg::kind_t'(kind))
        rgbled_pkg::KIND_WRITE: begin
          mem_we = 32'(entry_index) < 32'(TABLE_BYTES);
        end
        rgbled_pkg::KIND_START: begin
          sending_next = 1'b1;
          if (!busy) begin
            busy_next         = 1'b1;
            byte_count_next   = '0;
            bit_position_next = '0;
            slot_count_next   = '0;
            pos_next          = start_offset;
          end
        end
        rgbled_pkg::KIND_TICK: begin
          if (busy) begin
            sending_next = 1'b1;
            line_next    = slot_count < high;
            if (slot_inc >= bit_len) begin
              slot_count_next = '0;
              if (bit_position == 3'd7) begin
                bit_position_next = '0;
                if (byte_count == LAST) begin
                  // end of frame, move the start offset on
                  byte_count_next = '0;
                  busy_next       = 1'b0;
                  done_next       = 1'b1;
                  if (offset_sum >= SW'(TABLE_BYTES)) begin
                    start_offset_next = '0;
                  end else begin
                    start_offset_next = AW'(offset_sum);
                  end
                  pos_next = start_offset_next;
                end else begin
                  byte_count_next = byte_count + AW'(1);
                  pos_next        = (pos == LAST) ? '0 : pos + AW'(1);
                end
              end else begin
                bit_position_next = bit_position + 3'd1;
              end
            end else begin
              slot_count_next = slot_inc[3:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // table memory, read register always holds the byte at the next position
  always_ff @(posedge clk) begin
    if (mem_we) begin
      colour_table[mem_addr] <= entry_value;
    end
    if (mem_we && mem_addr == pos_next) begin
      rd_data <= entry_value;
    end else begin
      rd_data <= colour_table[pos_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      one_high  <= rgbled_pkg::ONE_HIGH_RST;
      zero_high <= rgbled_pkg::ZERO_HIGH_RST;
      bit_slots <= rgbled_pkg::BIT_SLOTS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rgbled_pkg::CFG_ONE_HIGH:  one_high  <= cfg_data[3:0];
        rgbled_pkg::CFG_ZERO_HIGH: zero_high <= cfg_data[3:0];
        rgbled_pkg::CFG_BIT_SLOTS: bit_slots <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset <= '0;
      byte_count   <= '0;
      pos          <= '0;
      bit_position <= '0;
      slot_count   <= '0;
      busy         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      start_offset <= start_offset_next;
      byte_count   <= byte_count_next;
      pos          <= pos_next;
      bit_position <= bit_position_next;
      slot_count   <= slot_count_next;
      busy         <= busy_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_level <= line_next;
      sending    <= sending_next;
      frame_done <= done_next;
    end
  end

endmodule

`default_nettype wire

### dv/led_frame_sb_pkg.sv
`timescale 1ns / 100ps

package led_frame_sb_pkg;
  import rgbled_pkg::*;

  typedef struct packed {
    logic line;
    logic sending;
    logic done;
  } slot_result_t;

  class led_frame_scoreboard;
    logic [7:0] colours [TABLE_BYTES_DEF];
    logic [4:0] offset;
    logic [4:0] byte_idx;
    logic [2:0] bit_idx;
    logic [4:0] slot_idx;
    logic       busy;
    logic [3:0] one_high;
    logic [3:0] zero_high;
    logic [4:0] bit_slots;
    slot_result_t expected_q [$];
    int unsigned worked;
    int unsigned writes;
    int unsigned ticks;
    int unsigned frames;
    int unsigned checked;
    int unsigned errors;

    function void reset();
      offset = '0;
      byte_idx = '0;
      bit_idx = '0;
      slot_idx = '0;
      busy = 1'b0;
      one_high = ONE_HIGH_RST;
      zero_high = ZERO_HIGH_RST;
      bit_slots = BIT_SLOTS_RST;
      expected_q.delete();
    endfunction

    function void set_reg(logic [1:0] idx, logic [4:0] data);
      case (idx)
        CFG_ONE_HIGH:  one_high = data[3:0];
        CFG_ZERO_HIGH: zero_high = data[3:0];
        CFG_BIT_SLOTS: bit_slots = data;
        default: ;
      endcase
    endfunction

    function logic [4:0] bit_len();
      if (bit_slots < BIT_SLOTS_MIN) return BIT_SLOTS_MIN;
      if (bit_slots > BIT_SLOTS_MAX) return BIT_SLOTS_MAX;
      return bit_slots;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // works out the slot result of one accepted request and advances the frame
    function void note_request(logic [1:0] k, logic [4:0] idx, logic [7:0] val);
      slot_result_t want;
      logic [5:0]   pos;
      logic         bit_val;
      logic [3:0]   high;
      want = '0;
      want.sending = busy;
      case (k)
        KIND_WRITE: begin
          if (idx < TABLE_BYTES_DEF) begin
            colours[idx] = val;
            writes++;
            worked++;
          end
        end
        KIND_START: begin
          if (!busy) begin
            busy = 1'b1;
            byte_idx = '0;
            bit_idx = '0;
            slot_idx = '0;
            worked++;
          end
          want.sending = 1'b1;
        end
        KIND_TICK: begin
          if (busy) begin
            pos = {1'b0, offset} + {1'b0, byte_idx};
            if (pos >= TABLE_BYTES_DEF) pos = 6'(pos - TABLE_BYTES_DEF);
            bit_val = colours[pos[4:0]][3'd7 - bit_idx];
            high = bit_val ? one_high : zero_high;
            want.line = (slot_idx < {1'b0, high});
            want.sending = 1'b1;
            slot_idx++;
            ticks++;
            worked++;
            if (slot_idx >= bit_len()) begin
              slot_idx = '0;
              if (bit_idx == 3'd7) begin
                bit_idx = '0;
                byte_idx++;
                if (byte_idx >= TABLE_BYTES_DEF) begin
                  byte_idx = '0;
                  busy = 1'b0;
                  want.done = 1'b1;
                  frames++;
                  // offset steps through the table and restarts at the end
                  if (offset + OFFSET_STEP_DEF >= TABLE_BYTES_DEF) offset = '0;
                  else offset = 5'(offset + OFFSET_STEP_DEF);
                end
              end else begin
                bit_idx++;
              end
            end
          end
        end
        default: ;
      endcase
      expected_q.push_back(want);
    endfunction

    function void check_result(logic line, logic snd, logic done);
      slot_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: line_level %0d sending %0d frame_done %0d",
               line, snd, done);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (line !== want.line) begin
        $error("line_level: expected %0d, got %0d", want.line, line);
        errors++;
      end
      if (snd !== want.sending) begin
        $error("sending: expected %0d, got %0d", want.sending, snd);
        errors++;
      end
      if (done !== want.done) begin
        $error("frame_done: expected %0d, got %0d", want.done, done);
        errors++;
      end
    endfunction
  endclass

endpackage

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rgbled_pkg::*;
  import led_frame_sb_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASES = 8;

  typedef struct {
    logic [4:0] one_hi;
    logic [4:0] zero_hi;
    logic [4:0] bit_slots;
    int         send_idle;
    int         recv_stall;
    int         count;
  } phase_t;

  // high times 0 and 15, bit lengths 2 and 16, and raw lengths that saturate
  phase_t plan [PHASES] = '{
    '{5'd15, 5'd1,  5'd16, 0,  0,  100},
    '{5'd1,  5'd15, 5'd2,  82, 0,  260},
    '{5'd0,  5'd15, 5'd0,  0,  82, 260},
    '{5'd15, 5'd0,  5'd31, 31, 31, 100},
    '{5'd3,  5'd1,  5'd1,  0,  0,  260},
    '{5'd2,  5'd1,  5'd3,  82, 0,  260},
    '{5'd9,  5'd4,  5'd17, 0,  82, 100},
    '{5'd15, 5'd15, 5'd4,  31, 31, 260}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] kind = '0;
  logic [4:0] entry_index = '0;
  logic [7:0] entry_value = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       line_level;
  logic       sending;
  logic       frame_done;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;

  led_frame_scoreboard sb;

  rgb_led_serial_frame_sender dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .line_level  (line_level),
    .sending     (sending),
    .frame_done  (frame_done)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(kind, entry_index, entry_value);
      if (out_valid && out_ready) sb.check_result(line_level, sending, frame_done);
    end
  end

  // receiver: random stalls, plus a long hold-off on request from the main thread
  always @(negedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(input logic [1:0] k, input logic [4:0] idx,
                           input logic [7:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    entry_index <= idx;
    entry_value <= val;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_timing(input logic [4:0] one_hi, input logic [4:0] zero_hi,
                              input logic [4:0] bit_slots);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ONE_HIGH;
    cfg_data <= one_hi;
    sb.set_reg(CFG_ONE_HIGH, one_hi);
    @(negedge clk);
    cfg_index <= CFG_ZERO_HIGH;
    cfg_data <= zero_hi;
    sb.set_reg(CFG_ZERO_HIGH, zero_hi);
    @(negedge clk);
    cfg_index <= CFG_BIT_SLOTS;
    cfg_data <= bit_slots;
    sb.set_reg(CFG_BIT_SLOTS, bit_slots);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly ticks while a frame runs, mostly starts and writes while idle
  task automatic send_random();
    logic [1:0] k;
    int         r;
    r = $urandom_range(99);
    if (sb.busy)
      k = (r < 88) ? KIND_TICK : (r < 94) ? KIND_WRITE : (r < 97) ? KIND_START : KIND_SPARE;
    else
      k = (r < 45) ? KIND_START : (r < 75) ? KIND_WRITE : (r < 88) ? KIND_TICK : KIND_SPARE;
    send_item(k, 5'($urandom), 8'($urandom));
  endtask

  task automatic run_phase(input int p);
    int unsigned base;
    bit          paused;
    paused = 1'b0;
    drain();
    write_timing(plan[p].one_hi, plan[p].zero_hi, plan[p].bit_slots);
    send_idle_pct = plan[p].send_idle;
    recv_stall_pct = plan[p].recv_stall;
    if (p == 0) hold_ask++;
    base = sb.worked;
    while (sb.worked - base < plan[p].count) begin
      // in phase 4 the sender stops halfway and lets every result come back
      if (p == 4 && !paused && sb.worked - base >= plan[p].count / 2) begin
        paused = 1'b1;
        drain();
      end
      send_random();
    end
  endtask

  initial begin
    sb = new();
    sb.reset();
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fill the whole table before any frame may read it
    for (int i = 0; i < TABLE_BYTES_DEF; i++)
      send_item(KIND_WRITE, i[4:0], (i == 0) ? 8'hFF : (i == 1) ? 8'h00 :
                (i == 2) ? 8'h80 : (i == 3) ? 8'h01 : 8'($urandom));
    send_item(KIND_TICK, 5'd0, 8'h00);
    send_item(KIND_SPARE, 5'd31, 8'hFF);
    send_item(KIND_WRITE, 5'd30, 8'h00);
    send_item(KIND_WRITE, 5'd31, 8'hFF);
    send_item(KIND_START, 5'd0, 8'h00);
    send_item(KIND_START, 5'd31, 8'hFF);
    repeat (12) send_item(KIND_TICK, 5'($urandom), 8'($urandom));
    send_item(KIND_WRITE, 5'd5, 8'h5A);
    send_item(KIND_SPARE, 5'd0, 8'h00);
    repeat (8) send_item(KIND_TICK, 5'($urandom), 8'($urandom));

    for (int p = 0; p < PHASES; p++) run_phase(p);
    drain();
    repeat (4) @(negedge clk);

    $display("tb_top: %0d slot results checked, %0d ticks in frames, %0d table writes",
             sb.checked, sb.ticks, sb.writes);
    $display("tb_top: %0d frames completed over %0d timing settings", sb.frames, PHASES + 1);
    if (sb.errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
